// ===== design/rkgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rkgs_pkg: shared types and helpers for the spring/gravity RK4 step
// Payload structs for the particle and result channels, register indexes and
// the signed 32-bit saturation function.
// ----------------------------------------------------------------------------
package rkgs_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [31:0] particle_mass;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_vx;
    logic signed [31:0] next_vy;
  } out_t;

  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_TOP       = 2'd1;

  localparam logic signed [59:0] DT_Q32 = 60'sd4294967;
  localparam logic [56:0] RECIP6 = 57'd715827882;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== design/rkgs_div.sv =====
// ----------------------------------------------------------------------------
// rkgs_div: pipelined restoring divider for the stiffness-to-mass ratio
// One quotient bit per stage; the particle travels alongside. The quotient
// saturates to all ones, which also covers a zero mass.
// ----------------------------------------------------------------------------
module rkgs_div import rkgs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  in_t         in_data,
  input  logic [31:0] num,
  output logic        out_valid,
  output in_t         out_data,
  output logic [31:0] out_ratio
);

  localparam int QW = 32 + FRAC_BITS;

  logic [31:0]   rem_r [QW];
  logic [QW-1:0] nq_r  [QW];
  logic [31:0]   den_r [QW];
  in_t           pl_r  [QW];
  logic [QW-1:0] v_r;

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [31:0]   rem_in;
    logic [QW-1:0] nq_in;
    logic [31:0]   den_in;
    in_t           pl_in;
    logic          v_in;
    logic [32:0]   t;
    logic          ge;
    logic [31:0]   rem_nxt;
    logic [QW-1:0] nq_nxt;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = {num, {FRAC_BITS{1'b0}}};
      assign den_in = in_data.particle_mass;
      assign pl_in  = in_data;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign pl_in  = pl_r[i-1];
      assign v_in   = v_r[i-1];
    end

    assign t       = {rem_in, nq_in[QW-1]};
    assign ge      = (t >= {1'b0, den_in});
    assign rem_nxt = ge ? 32'(t - {1'b0, den_in}) : t[31:0];
    assign nq_nxt  = {nq_in[QW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        nq_r[i]  <= nq_nxt;
        den_r[i] <= den_in;
        pl_r[i]  <= pl_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_data  = pl_r[QW-1];
  assign out_ratio = (|nq_r[QW-1][QW-1:32]) ? 32'hFFFFFFFF : nq_r[QW-1][31:0];

endmodule

// ===== design/rkgs_core.sv =====
// ----------------------------------------------------------------------------
// rkgs_core: RK4 stage pipeline
// Fourteen register stages evaluate the four spring/gravity stages, the
// weighted sums, the division by six and the final saturating updates.
// ----------------------------------------------------------------------------
module rkgs_core import rkgs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  in_t                in_data,
  input  logic        [31:0] in_ratio,
  input  logic signed [31:0] spring_top,
  output logic               out_valid,
  output out_t               out_data
);

  localparam int NS = 14;
  localparam logic signed [31:0] GRAV = 32'(((98 << FRAC_BITS) + 5) / 10);

  typedef struct packed {
    logic        [31:0] r;
    logic               on;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] nx;
    logic signed [31:0] ys;
    logic signed [31:0] k1v;
    logic signed [31:0] k2y;
    logic signed [31:0] k2v;
    logic signed [31:0] k3y;
    logic signed [31:0] k3v;
    logic signed [31:0] k4y;
    logic signed [31:0] k4v;
    logic signed [64:0] ma;
    logic signed [59:0] p;
    logic signed [59:0] q;
    logic signed [35:0] sy;
    logic signed [35:0] sv;
    logic        [26:0] uy;
    logic        [26:0] uv;
    logic        [56:0] my;
    logic        [56:0] mv;
    logic               neg_y;
    logic               neg_v;
  } rk_t;

  rk_t           st_r   [NS];
  rk_t           st_nxt [NS];
  logic [NS-1:0] v_r;

  function automatic logic signed [64:0] sprod(input logic [31:0] r,
                                               input logic signed [31:0] top,
                                               input logic signed [31:0] h);
    logic signed [65:0] d;
    logic signed [64:0] a;
    logic signed [64:0] b;
    d = 66'(top) - 66'(h);
    a = $signed({33'b0, r});
    b = 65'(sat32(d));
    return a * b;
  endfunction

  function automatic logic signed [31:0] accel(input logic on,
                                               input logic signed [64:0] m);
    logic signed [65:0] t;
    t = 66'(m >>> FRAC_BITS) - 66'(GRAV);
    return on ? sat32(t) : -GRAV;
  endfunction

  function automatic logic signed [59:0] dtmul(input logic signed [35:0] v);
    logic signed [59:0] a;
    a = 60'(v);
    return a * DT_Q32;
  endfunction

  function automatic logic signed [31:0] addsat(input logic signed [31:0] a,
                                                input logic signed [59:0] p,
                                                input logic full);
    logic signed [65:0] s;
    s = 66'(a) + (full ? 66'(p >>> 32) : 66'(p >>> 33));
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] finish(input logic signed [31:0] base,
                                                input logic [26:0] u,
                                                input logic [56:0] m,
                                                input logic neg);
    logic [24:0]        q0;
    logic [27:0]        r0;
    logic [25:0]        q;
    logic signed [65:0] res;
    q0  = m[56:32];
    r0  = 28'(u) - 28'(q0) * 28'd6;
    q   = (r0 >= 28'd6) ? 26'(q0) + 26'd1 : 26'(q0);
    res = neg ? -66'sd1 - 66'(q) : 66'(q);
    return sat32(66'(base) + res);
  endfunction

  always_comb begin
    st_nxt[0]    = '0;
    st_nxt[0].r  = in_ratio;
    st_nxt[0].x  = in_data.pos_x;
    st_nxt[0].y  = in_data.pos_y;
    st_nxt[0].vx = in_data.vel_x;
    st_nxt[0].vy = in_data.vel_y;
    st_nxt[0].on = (in_data.pos_y <= spring_top);
    st_nxt[0].ma = sprod(in_ratio, spring_top, in_data.pos_y);
    st_nxt[0].p  = dtmul(36'(in_data.vel_y));
    st_nxt[0].q  = dtmul(36'(in_data.vel_x));
    for (int i = 1; i < NS; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    st_nxt[1].k1v = accel(st_r[0].on, st_r[0].ma);
    st_nxt[1].ys  = addsat(st_r[0].y, st_r[0].p, 1'b0);
    st_nxt[1].nx  = addsat(st_r[0].x, st_r[0].q, 1'b1);

    st_nxt[2].p  = dtmul(36'(st_r[1].k1v));
    st_nxt[2].ma = sprod(st_r[1].r, spring_top, st_r[1].ys);

    st_nxt[3].k2y = addsat(st_r[2].vy, st_r[2].p, 1'b0);
    st_nxt[3].k2v = accel(st_r[2].on, st_r[2].ma);

    st_nxt[4].p = dtmul(36'(st_r[3].k2v));
    st_nxt[4].q = dtmul(36'(st_r[3].k2y));

    st_nxt[5].k3y = addsat(st_r[4].vy, st_r[4].p, 1'b0);
    st_nxt[5].ys  = addsat(st_r[4].y, st_r[4].q, 1'b0);

    st_nxt[6].ma = sprod(st_r[5].r, spring_top, st_r[5].ys);
    st_nxt[6].p  = dtmul(36'(st_r[5].k3y));

    st_nxt[7].k3v = accel(st_r[6].on, st_r[6].ma);
    st_nxt[7].ys  = addsat(st_r[6].y, st_r[6].p, 1'b1);

    st_nxt[8].ma = sprod(st_r[7].r, spring_top, st_r[7].ys);
    st_nxt[8].p  = dtmul(36'(st_r[7].k3v));

    st_nxt[9].k4v = accel(st_r[8].on, st_r[8].ma);
    st_nxt[9].k4y = addsat(st_r[8].vy, st_r[8].p, 1'b1);

    st_nxt[10].sy = 36'(st_r[9].vy) + (36'(st_r[9].k2y) <<< 1)
                  + (36'(st_r[9].k3y) <<< 1) + 36'(st_r[9].k4y);
    st_nxt[10].sv = 36'(st_r[9].k1v) + (36'(st_r[9].k2v) <<< 1)
                  + (36'(st_r[9].k3v) <<< 1) + 36'(st_r[9].k4v);

    st_nxt[11].p = dtmul(st_r[10].sy);
    st_nxt[11].q = dtmul(st_r[10].sv);

    st_nxt[12].neg_y = st_r[11].p[59];
    st_nxt[12].neg_v = st_r[11].q[59];
    st_nxt[12].uy    = st_r[11].p[59] ? ~st_r[11].p[58:32] : st_r[11].p[58:32];
    st_nxt[12].uv    = st_r[11].q[59] ? ~st_r[11].q[58:32] : st_r[11].q[58:32];
    st_nxt[12].my    = 57'(st_nxt[12].uy) * RECIP6;
    st_nxt[12].mv    = 57'(st_nxt[12].uv) * RECIP6;

    st_nxt[13].y  = finish(st_r[12].y, st_r[12].uy, st_r[12].my, st_r[12].neg_y);
    st_nxt[13].vy = finish(st_r[12].vy, st_r[12].uv, st_r[12].mv, st_r[12].neg_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_valid        = v_r[NS-1];
  assign out_data.next_x  = st_r[NS-1].nx;
  assign out_data.next_y  = st_r[NS-1].y;
  assign out_data.next_vx = st_r[NS-1].vx;
  assign out_data.next_vy = st_r[NS-1].vy;

endmodule

// ===== design/rk4_spring_gravity_step.sv =====
// Pipeline: 32 + FRAC_BITS divider stages, 14 RK4 stages and one output
// buffer stage. Throughput: one particle per cycle while the output buffer
// is not full or the output is ready; the ratio divider retires one quotient
// bit per stage and the RK4 stages hold at most one multiplier level each.
// Reset is synchronous and active low; it clears valid bits, the output
// buffer count and both configuration registers.
// ----------------------------------------------------------------------------
// rk4_spring_gravity_step: one RK4 time step for a particle on a spring
// Configuration registers, ratio divider, RK4 pipeline and a two-entry
// output buffer that lets the pipeline keep moving while a result waits.
// ----------------------------------------------------------------------------
module rk4_spring_gravity_step import rkgs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        [31:0] stiff_r;
  logic signed [31:0] top_r;
  logic               adv;
  logic               div_valid;
  in_t                div_data;
  logic        [31:0] div_ratio;
  logic               core_valid;
  out_t               core_data;
  out_t               buf_r [2];
  logic        [1:0]  cnt_r;
  logic        [1:0]  cnt_nxt;
  logic               push;
  logic               pop;
  logic               wr_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= '0;
      top_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STIFFNESS: stiff_r <= cfg_data;
        REG_TOP:       top_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign adv      = (cnt_r < 2'd2) || out_ready;
  assign in_ready = adv;

  rkgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .num       (stiff_r),
    .out_valid (div_valid),
    .out_data  (div_data),
    .out_ratio (div_ratio)
  );

  rkgs_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (div_valid),
    .in_data    (div_data),
    .in_ratio   (div_ratio),
    .spring_top (top_r),
    .out_valid  (core_valid),
    .out_data   (core_data)
  );

  assign push    = adv && core_valid;
  assign pop     = out_valid && out_ready;
  assign cnt_nxt = cnt_r - {1'b0, pop} + {1'b0, push};
  assign wr_idx  = 1'(cnt_r - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_idx) begin
      buf_r[0] <= core_data;
    end else if (pop) begin
      buf_r[0] <= buf_r[1];
    end
    if (push && wr_idx) begin
      buf_r[1] <= core_data;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("output buffer count out of range");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cnt_r == 2'd2) |-> pop) else $error("push into full output buffer");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_ready) |-> !in_ready)
    else $error("input transaction taken while output buffer is full");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the spring/gravity RK4 particle step
// Directed and random particles are streamed through the block under random
// input and output stalls. Each result is compared field by field with an
// in-bench predictor of the fixed-point RK4 step.
// ----------------------------------------------------------------------------
module tb_top;
  import rkgs_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint DT = 64'sd4294967;
  localparam longint GRAV = ((longint'(98) << FRAC) + 5) / 10;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_STIFFNESS;
  logic [31:0] cfg_data = '0;

  longint stiffness_q;
  longint spring_top_q;
  out_t expected_steps[$];
  int errors = 0;
  int idle_pct = 26;
  int stall_pct = 26;
  int quiet_cycles = 0;

  rk4_spring_gravity_step #(.FRAC_BITS(FRAC)) uut (.*);

  always #5 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_by6(longint v);
    if (v >= 0) return v / 6;
    return -((-1 - v + 6) / 6);
  endfunction

  function automatic longint spring_accel(bit on_spring, longint ratio, longint h);
    longint diff;
    if (!on_spring) return -GRAV;
    diff = clamp32(spring_top_q - h);
    return clamp32(floor_shr(ratio * diff, FRAC) - GRAV);
  endfunction

  function automatic longint weighted_step(longint a, longint b, longint c, longint d);
    longint s;
    s = a + 2 * b + 2 * c + d;
    return floor_by6(floor_shr(s * DT, 32));
  endfunction

  function automatic out_t predict_step(in_t p);
    longint y, vy, ratio;
    longint k1y, k1v, k2y, k2v, k3y, k3v, k4y, k4v;
    bit on_spring;
    out_t r;
    y = longint'(p.pos_y);
    vy = longint'(p.vel_y);
    on_spring = (y <= spring_top_q);
    if (p.particle_mass == 0) begin
      ratio = 64'hFFFFFFFF;
    end else begin
      ratio = (stiffness_q << FRAC) / longint'({32'd0, p.particle_mass});
      if (ratio > 64'hFFFFFFFF) ratio = 64'hFFFFFFFF;
    end
    k1y = vy;
    k1v = spring_accel(on_spring, ratio, y);
    k2y = clamp32(vy + floor_shr(k1v * DT, 33));
    k2v = spring_accel(on_spring, ratio, clamp32(y + floor_shr(k1y * DT, 33)));
    k3y = clamp32(vy + floor_shr(k2v * DT, 33));
    k3v = spring_accel(on_spring, ratio, clamp32(y + floor_shr(k2y * DT, 33)));
    k4y = clamp32(vy + floor_shr(k3v * DT, 32));
    k4v = spring_accel(on_spring, ratio, clamp32(y + floor_shr(k3y * DT, 32)));
    r.next_x = 32'(clamp32(longint'(p.pos_x) + floor_shr(longint'(p.vel_x) * DT, 32)));
    r.next_y = 32'(clamp32(y + weighted_step(k1y, k2y, k3y, k4y)));
    r.next_vx = p.vel_x;
    r.next_vy = 32'(clamp32(vy + weighted_step(k1v, k2v, k3v, k4v)));
    return r;
  endfunction

  task automatic send_particle(in_t p);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_steps.insert(expected_steps.size(), predict_step(p));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_STIFFNESS) stiffness_q = longint'({32'd0, val});
    else if (idx == REG_TOP) spring_top_q = longint'($signed(val));
    @(posedge clk);
  endtask

  function automatic in_t rand_particle(int heavy);
    in_t p;
    p.pos_x = $urandom();
    p.vel_x = $urandom();
    p.particle_mass = $urandom();
    if (heavy != 0) begin
      p.pos_y = $urandom();
      p.vel_y = $urandom();
    end else begin
      p.pos_y = 32'(spring_top_q + $signed($urandom_range(2000000)) - 1000000);
      p.vel_y = $signed($urandom_range(2000000)) - 1000000;
      if ($urandom_range(3) == 0) p.particle_mass = $urandom_range(1 << 20);
    end
    return p;
  endfunction

  task automatic test_directed();
    in_t p;
    logic [31:0] ext[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    write_reg(REG_STIFFNESS, 32'h0001_0000);
    write_reg(REG_TOP, 32'h0000_0000);
    for (int i = 0; i < 4; i++) begin
      p.pos_x = ext[i];
      p.pos_y = ext[(i + 1) % 4];
      p.vel_x = ext[i];
      p.vel_y = ext[(i + 2) % 4];
      p.particle_mass = ext[(i + 3) % 4];
      send_particle(p);
    end
    p = '{32'sh10000, 32'sh0, 32'sh10000, 32'sh0, 32'h0};
    send_particle(p);
    p.pos_y = 32'sh1;
    send_particle(p);
    p.pos_y = -32'sh1;
    p.particle_mass = 32'h1;
    send_particle(p);
    p = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'h1};
    send_particle(p);
    p = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'hFFFFFFFF};
    send_particle(p);
    wait_drained();
    write_reg(REG_STIFFNESS, 32'hFFFFFFFF);
    write_reg(REG_TOP, 32'h7FFFFFFF);
    for (int i = 0; i < 4; i++) send_particle(rand_particle(1));
    p = '{32'sh0, 32'sh7FFFFFFF, 32'sh0, 32'sh0, 32'h0};
    send_particle(p);
    wait_drained();
    write_reg(REG_TOP, 32'h80000000);
    p = '{32'sh0, 32'sh80000000, 32'sh0, 32'sh0, 32'h1};
    send_particle(p);
    send_particle(rand_particle(1));
    wait_drained();
    write_reg(2'd2, 32'h1234_5678);
    write_reg(2'd3, 32'hFFFF_FFFF);
    send_particle(p);
    wait_drained();
  endtask

  task automatic test_random_phase(logic [31:0] k, logic [31:0] top, int count, int quiet);
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_TOP, top);
    idle_pct = quiet ? 0 : 26;
    stall_pct = quiet ? 0 : 26;
    for (int i = 0; i < count; i++) begin
      send_particle(rand_particle(int'($urandom_range(4) == 0)));
      if (i == count / 2) begin
        in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge clk);
      end
    end
    wait_drained();
    idle_pct = 26;
    stall_pct = 26;
  endtask

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          errors++;
        end else begin
          exp_r = expected_steps.pop_front();
          if (out_data.next_x !== exp_r.next_x) begin
            $error("next_x expected %0d actual %0d", exp_r.next_x, out_data.next_x);
            errors++;
          end
          if (out_data.next_y !== exp_r.next_y) begin
            $error("next_y expected %0d actual %0d", exp_r.next_y, out_data.next_y);
            errors++;
          end
          if (out_data.next_vx !== exp_r.next_vx) begin
            $error("next_vx expected %0d actual %0d", exp_r.next_vx, out_data.next_vx);
            errors++;
          end
          if (out_data.next_vy !== exp_r.next_vy) begin
            $error("next_vy expected %0d actual %0d", exp_r.next_vy, out_data.next_vy);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rk4_spring_gravity_step test failed");
      $finish;
    end
  end

  initial begin
    stiffness_q = 0;
    spring_top_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(32'h0000_0000, 32'h0000_0000, 100, 0);
    test_random_phase(32'h0010_0000, 32'h0050_0000, 150, 1);
    test_random_phase($urandom(), $urandom(), 150, 0);
    test_random_phase(32'hFFFF_FFFF, 32'h8000_0000, 100, 0);
    test_random_phase(32'h0000_0001, 32'h7FFF_FFFF, 130, 0);
    if (errors == 0) begin
      $display("rk4_spring_gravity_step test passed");
    end else begin
      $display("rk4_spring_gravity_step test failed");
    end
    $finish;
  end

endmodule
